@@ hw/rtl/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants for the per-destination token bucket policer.
// ----------------------------------------------------------------------------
package tbp_pkg;

   localparam int KEY_W   = 32;
   localparam int SIZE_W  = 16;
   localparam int TIME_W  = 63;
   localparam int CFG_W   = 16;
   localparam int TOK_W   = 16;
   localparam int OUT_W   = 3;
   localparam int FREED_W = 9;
   localparam int CSR_IDX_W = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BURST = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE  = 1'b1;

   // result outcome codes
   localparam logic [OUT_W-1:0] OUT_HIT_PASS = 3'd0;
   localparam logic [OUT_W-1:0] OUT_HIT_DROP = 3'd1;
   localparam logic [OUT_W-1:0] OUT_NEW_PASS = 3'd2;
   localparam logic [OUT_W-1:0] OUT_TOO_BIG  = 3'd3;
   localparam logic [OUT_W-1:0] OUT_FULL     = 3'd4;
   localparam logic [OUT_W-1:0] OUT_EXPIRE   = 3'd5;

   // operation broadcast to every cell
   typedef enum logic [2:0] {
      CELL_IDLE,
      CELL_NEW,
      CELL_HIT,
      CELL_EXPIRE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [KEY_W-1:0]   key;
      logic [TOK_W-1:0]   level;
      logic [TIME_W-1:0]  stamp;
   } cell_cmd_type;

   // level and stamp are zero unless the cell hits, so they can be OR-gathered
   typedef struct packed {
      logic               hit;
      logic               flag;
      logic [TOK_W-1:0]   level;
      logic [TIME_W-1:0]  stamp;
   } cell_stat_type;

endpackage

@@ hw/rtl/tbp_cell.sv @@
// ----------------------------------------------------------------------------
// tbp_cell
// One table entry: key, token level, last time, valid bit and a freed flag
// that shifts toward cell zero during the count after an expire sweep.
// ----------------------------------------------------------------------------
module tbp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tbp_pkg::cell_cmd_type cmd,
   input  logic                  take_in,
   output logic                  take_out,
   input  logic                  flag_shift,
   output tbp_pkg::cell_stat_type stat
);
   import tbp_pkg::*;

   logic               valid_ff, valid_in;
   logic               flag_ff, flag_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [TOK_W-1:0]   level_ff, level_in;
   logic [TIME_W-1:0]  stamp_ff, stamp_in;
   logic               hit;
   logic               sel_new;
   logic               stale;

   // match, free-slot priority chain and age test
   assign hit      = valid_ff && (key_ff == cmd.key);
   assign sel_new  = !valid_ff && !take_in;
   assign take_out = take_in || !valid_ff;
   assign stale    = valid_ff && (stamp_ff < cmd.stamp);

   // apply the broadcast operation
   always_comb begin
      valid_in = valid_ff;
      flag_in  = flag_ff;
      key_in   = key_ff;
      level_in = level_ff;
      stamp_in = stamp_ff;
      case (cmd.op)
         CELL_NEW: begin
            if (sel_new) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               level_in = cmd.level;
               stamp_in = cmd.stamp;
            end
         end
         CELL_HIT: begin
            if (hit) begin
               level_in = cmd.level;
               stamp_in = cmd.stamp;
            end
         end
         CELL_EXPIRE: begin
            flag_in = stale;
            if (stale) begin
               valid_in = 1'b0;
            end
         end
         CELL_SHIFT: begin
            flag_in = flag_shift;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         flag_ff  <= flag_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      level_ff <= level_in;
      stamp_ff <= stamp_in;
   end

   assign stat.hit   = hit;
   assign stat.flag  = flag_ff;
   assign stat.level = hit ? level_ff : '0;
   assign stat.stamp = hit ? stamp_ff : '0;

endmodule

@@ hw/rtl/tbp_divider.sv @@
// ----------------------------------------------------------------------------
// tbp_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbp_divider #(
   parameter int DIVD_W = 63,
   parameter int DIVS_W = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dsr_ff, dsr_in;
   logic [DIVS_W:0]   trial;
   logic              fits;

   // shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         rem_in = fits ? DIVS_W'(trial - {1'b0, dsr_ff}) : trial[DIVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/per_destination_token_bucket_policer.sv @@
// ----------------------------------------------------------------------------
// per_destination_token_bucket_policer
// Token bucket policer keyed by destination address, one entry per cell.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | mode, dest_addr, pkt_size, now
//  rsp     | out       | rsp_valid/stall  | forward, outcome, freed_count
//  csr     | in        | csr_write_en     | csr_index, csr_wdata
//
//  One item at a time. A packet miss goes from lookup straight to the result;
//  a packet hit adds a radix-16 division of gap*rate by TICKS_PER_SECOND.
//  An expire item runs the bit-serial burst/rate divider, then a count that
//  shifts the freed flags out of the cell row one per cycle.
//  Synchronous reset clears all valid bits at once; no clearing pass.
//  The next item is taken while a result waits under rsp_stall.
// ----------------------------------------------------------------------------
module per_destination_token_bucket_policer #(
   parameter int CAPACITY         = 256,
   parameter int TICKS_PER_SECOND = 1000000000
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic [tbp_pkg::KEY_W-1:0]      req_dest_addr,
   input  logic [tbp_pkg::SIZE_W-1:0]     req_pkt_size,
   input  logic [tbp_pkg::TIME_W-1:0]     req_now,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_forward,
   output logic [tbp_pkg::OUT_W-1:0]      rsp_outcome,
   output logic [tbp_pkg::FREED_W-1:0]    rsp_freed_count,
   input  logic                           csr_write_en,
   input  logic [tbp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tbp_pkg::CFG_W-1:0]      csr_wdata
);
   import tbp_pkg::*;

   localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
   localparam int GAP_W  = CFG_W + TPS_W;
   localparam int PROD_W = GAP_W + 1 + CFG_W;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DIG_W  = 4;
   localparam int NDIG   = TOK_W / DIG_W;
   localparam logic [TPS_W-1:0] TPS = TPS_W'(TICKS_PER_SECOND);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_LOOKUP = 11'b00000000010,
      ST_CALC   = 11'b00000000100,
      ST_CMP    = 11'b00000001000,
      ST_TDIV   = 11'b00000010000,
      ST_DIVW   = 11'b00000100000,
      ST_APPLY  = 11'b00001000000,
      ST_AGE    = 11'b00010000000,
      ST_SWEEP  = 11'b00100000000,
      ST_COUNT  = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     burst_ff, burst_in;
   logic [CFG_W-1:0]     rate_ff, rate_in;
   logic [CFG_W-1:0]     rate_eff;

   logic                 mode_ff;
   logic [KEY_W-1:0]     addr_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [TIME_W-1:0]    now_ff;

   logic [TOK_W-1:0]     hit_level_ff;
   logic [TIME_W-1:0]    hit_stamp_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [GAP_W-1:0]     bxt_ff;
   logic                 small_ff;
   logic                 cond_ff;
   logic [GAP_W-1:0]     age_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [TPS_W-1:0]     tdiv_rem_ff;
   logic [TOK_W-1:0]     tdiv_low_ff;
   logic [TOK_W-1:0]     tdiv_quo_ff;
   logic [1:0]           tdiv_cnt_ff;
   logic [PROD_W-1:0]    refill_prod;
   logic [TPS_W+DIG_W-1:0] tdiv_win;
   logic [TPS_W+DIG_W-1:0] tdiv_sub;
   logic [TPS_W+DIG_W-1:0] tdiv_diff;
   logic [DIG_W-1:0]     tdiv_dig;

   logic                 res_fwd_ff, res_fwd_in;
   logic [OUT_W-1:0]     res_out_ff, res_out_in;
   logic [FREED_W-1:0]   freed_ff, freed_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_fwd_ff;
   logic [OUT_W-1:0]     rsp_out_ff;
   logic [FREED_W-1:0]   rsp_freed_ff;
   logic                 rsp_load;

   logic                 req_take;
   cell_cmd_type         cmd;
   cell_stat_type        stat [CAPACITY];
   logic [CAPACITY:0]    take;
   logic [CAPACITY-1:0]  flag_chain;
   logic                 any_hit;
   logic [TOK_W-1:0]     g_level;
   logic [TIME_W-1:0]    g_stamp;
   logic                 table_full;

   logic [TIME_W:0]      gap_full;
   logic [GAP_W:0]       gap_p1;
   logic                 small_gap;
   logic                 div_start;
   logic                 div_done;
   logic [CFG_W-1:0]     div_quo;
   logic [TOK_W:0]       sum;
   logic [TOK_W-1:0]     lvl;
   logic                 pass;
   logic [TIME_W-1:0]    limit;

   assign rate_eff = (rate_ff == '0) ? CFG_W'(1) : rate_ff;
   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // cell row
   assign take[0] = 1'b0;
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         if (gi == CAPACITY - 1) begin : g_last
            assign flag_chain[gi] = 1'b0;
         end else begin : g_mid
            assign flag_chain[gi] = stat[gi+1].flag;
         end
         tbp_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .take_in    (take[gi]),
            .take_out   (take[gi+1]),
            .flag_shift (flag_chain[gi]),
            .stat       (stat[gi])
         );
      end
   endgenerate

   // gather the single matching entry
   always_comb begin
      any_hit = 1'b0;
      g_level = '0;
      g_stamp = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_hit = any_hit | stat[i].hit;
         g_level = g_level | stat[i].level;
         g_stamp = g_stamp | stat[i].stamp;
      end
   end
   assign table_full = !take[CAPACITY];

   // refill arithmetic
   assign gap_full  = {1'b0, now_ff} - {1'b0, hit_stamp_ff};
   assign small_gap = !gap_full[TIME_W] && (gap_full[TIME_W-1:GAP_W] == '0);
   assign gap_p1    = {1'b0, gap_full[GAP_W-1:0]} + (GAP_W+1)'(1);
   assign refill_prod = prod_ff - PROD_W'(rate_eff);

   // radix-16 division of gap*rate by the tick rate, one digit per cycle;
   // the quotient is only used when it is below burst, so 16 bits suffice
   assign tdiv_win = {tdiv_rem_ff, tdiv_low_ff[TOK_W-1:TOK_W-DIG_W]};
   always_comb begin
      tdiv_dig = '0;
      tdiv_sub = '0;
      for (int d = 1; d < (1 << DIG_W); d++) begin
         if (tdiv_win >= (TPS_W+DIG_W)'(64'(d) * 64'(TICKS_PER_SECOND))) begin
            tdiv_dig = DIG_W'(d);
            tdiv_sub = (TPS_W+DIG_W)'(64'(d) * 64'(TICKS_PER_SECOND));
         end
      end
   end
   assign tdiv_diff = tdiv_win - tdiv_sub;

   // burst / rate for the expiry age
   assign div_start = (state_ff == ST_LOOKUP) && !mode_ff;

   tbp_divider #(
      .DIVD_W (CFG_W),
      .DIVS_W (CFG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (burst_ff),
      .divisor  (rate_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign sum  = {1'b0, hit_level_ff} + {1'b0, tdiv_quo_ff};
   assign lvl  = !cond_ff ? burst_ff :
                 (sum > {1'b0, burst_ff}) ? burst_ff : sum[TOK_W-1:0];
   assign pass = lvl > size_ff;
   assign limit = (now_ff >= TIME_W'(age_ff)) ? (now_ff - TIME_W'(age_ff)) : '0;

   // sequencer and cell commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      res_fwd_in = res_fwd_ff;
      res_out_in = res_out_ff;
      freed_in   = freed_ff;
      cmd.op     = CELL_IDLE;
      cmd.key    = addr_ff;
      cmd.level  = burst_ff - size_ff;
      cmd.stamp  = now_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               freed_in = '0;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!mode_ff) begin
               state_in = ST_DIVW;
            end else if (any_hit) begin
               state_in = ST_CALC;
            end else if (size_ff > burst_ff) begin
               res_fwd_in = 1'b0;
               res_out_in = OUT_TOO_BIG;
               state_in   = ST_DONE;
            end else if (table_full) begin
               res_fwd_in = 1'b0;
               res_out_in = OUT_FULL;
               state_in   = ST_DONE;
            end else begin
               cmd.op     = CELL_NEW;
               res_fwd_in = 1'b1;
               res_out_in = OUT_NEW_PASS;
               state_in   = ST_DONE;
            end
         end
         ST_CALC: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            if (tdiv_cnt_ff == 2'(NDIG - 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_DIVW: begin
            if (div_done) begin
               state_in = ST_AGE;
            end
         end
         ST_APPLY: begin
            cmd.op     = CELL_HIT;
            cmd.level  = pass ? (lvl - size_ff) : lvl;
            res_fwd_in = pass;
            res_out_in = pass ? OUT_HIT_PASS : OUT_HIT_DROP;
            state_in   = ST_DONE;
         end
         ST_AGE: begin
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.op     = CELL_EXPIRE;
            cmd.stamp  = limit;
            cnt_in     = '0;
            res_fwd_in = 1'b0;
            res_out_in = OUT_EXPIRE;
            state_in   = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.op   = CELL_SHIFT;
            freed_in = freed_ff + FREED_W'(stat[0].flag);
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CAPACITY - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      burst_in = burst_ff;
      rate_in  = rate_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BURST: burst_in = csr_wdata;
            CSR_RATE:  rate_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         burst_ff     <= CFG_W'(65535);
         rate_ff      <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         burst_ff     <= burst_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      res_fwd_ff <= res_fwd_in;
      res_out_ff <= res_out_in;
      freed_ff   <= freed_in;
      if (req_take) begin
         mode_ff <= req_mode;
         addr_ff <= req_dest_addr;
         size_ff <= req_pkt_size;
         now_ff  <= req_now;
      end
      if (state_ff == ST_LOOKUP) begin
         hit_level_ff <= g_level;
         hit_stamp_ff <= g_stamp;
      end
      if (state_ff == ST_CALC) begin
         prod_ff  <= PROD_W'(gap_p1 * rate_eff);
         bxt_ff   <= GAP_W'(burst_ff * TPS);
         small_ff <= small_gap;
      end
      if (state_ff == ST_CMP) begin
         cond_ff     <= small_ff && (prod_ff <= PROD_W'(bxt_ff));
         tdiv_rem_ff <= refill_prod[GAP_W-1:TOK_W];
         tdiv_low_ff <= refill_prod[TOK_W-1:0];
         tdiv_cnt_ff <= '0;
      end
      if (state_ff == ST_TDIV) begin
         tdiv_rem_ff <= tdiv_diff[TPS_W-1:0];
         tdiv_low_ff <= {tdiv_low_ff[TOK_W-DIG_W-1:0], DIG_W'(0)};
         tdiv_quo_ff <= {tdiv_quo_ff[TOK_W-DIG_W-1:0], tdiv_dig};
         tdiv_cnt_ff <= tdiv_cnt_ff + 2'd1;
      end
      if (state_ff == ST_AGE) begin
         age_ff <= GAP_W'(TPS * div_quo);
      end
      if (rsp_load) begin
         rsp_fwd_ff   <= res_fwd_ff;
         rsp_out_ff   <= res_out_ff;
         rsp_freed_ff <= freed_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_forward     = rsp_fwd_ff;
   assign rsp_outcome     = rsp_out_ff;
   assign rsp_freed_count = rsp_freed_ff;

endmodule

@@ hw/rtl/tbp_checker.sv @@
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level checks on the policer's result and request channels.
// ----------------------------------------------------------------------------
module tbp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_forward,
   input logic [tbp_pkg::OUT_W-1:0]      rsp_outcome,
   input logic [tbp_pkg::FREED_W-1:0]    rsp_freed_count
);
   import tbp_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_freed_count) && $stable(rsp_forward))
      else $error("stalled result changed");

   // forward only on a passing outcome
   a_fwd_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forward |-> rsp_outcome == OUT_HIT_PASS
         || rsp_outcome == OUT_NEW_PASS)
      else $error("forward on a drop outcome");

   // freed count only on an expire transfer
   a_freed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != OUT_EXPIRE |-> rsp_freed_count == '0)
      else $error("freed count on a packet result");

   // one item in flight: taking a request raises req_stall
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transfer taken while busy");

endmodule

bind per_destination_token_bucket_policer tbp_checker u_tbp_checker (.*);

@@ verif/tb_per_destination_token_bucket_policer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_destination_token_bucket_policer
// Self-checking bench: a queue-fed driver offers packet and expire items, a
// shadow flow table predicts each verdict, and a monitor compares results.
// ----------------------------------------------------------------------------
module tb_per_destination_token_bucket_policer;
   import tbp_pkg::*;

   localparam int          NUM_SLOTS = 256;
   localparam logic [63:0] TICKS     = 64'd1000000000;
   localparam int          MAX_CYCLES = 2000000;

   typedef struct {
      logic              mode;
      logic [KEY_W-1:0]  addr;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] now;
   } pkt_item_type;

   typedef struct {
      logic               forward;
      logic [OUT_W-1:0]   outcome;
      logic [FREED_W-1:0] freed;
   } verdict_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_mode = 1'b0;
   logic [KEY_W-1:0]     req_dest_addr = '0;
   logic [SIZE_W-1:0]    req_pkt_size = '0;
   logic [TIME_W-1:0]    req_now = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_forward;
   logic [OUT_W-1:0]     rsp_outcome;
   logic [FREED_W-1:0]   rsp_freed_count;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BURST;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // shadow flow table and registers
   logic [KEY_W-1:0]  tbl_key   [NUM_SLOTS];
   logic              tbl_valid [NUM_SLOTS];
   logic [TOK_W-1:0]  tbl_level [NUM_SLOTS];
   logic [TIME_W-1:0] tbl_stamp [NUM_SLOTS];
   logic [CFG_W-1:0]  cfg_burst = 16'hFFFF;
   logic [CFG_W-1:0]  cfg_rate  = 16'd1;

   pkt_item_type pending_pkts[$];
   verdict_type  expected_verdicts[$];
   int        errors = 0;
   int        cycles = 0;
   int        idle_mode = 0;
   logic      hold_req = 1'b0;
   logic      hold_done = 1'b0;
   int        hold_left = 0;
   logic [TIME_W-1:0] clk_now = '0;
   logic [KEY_W-1:0]  addr_pool[64];

   per_destination_token_bucket_policer u_dut (.*);

   always #2 clock = ~clock;

   // compute the verdict for one item and update the shadow table
   function automatic verdict_type police_item(pkt_item_type it);
      logic [63:0] rate, burst, gap, lvl, age, lim;
      int          slot, i, freed;
      verdict_type v;
      rate  = (cfg_rate == 0) ? 64'd1 : 64'(cfg_rate);
      burst = 64'(cfg_burst);
      v     = '{1'b0, OUT_EXPIRE, '0};
      slot  = -1;
      if (!it.mode) begin
         age   = TICKS * (burst / rate);
         freed = 0;
         if (64'(it.now) >= age) begin
            lim = 64'(it.now) - age;
            for (i = 0; i < NUM_SLOTS; i++)
               if (tbl_valid[i] && 64'(tbl_stamp[i]) < lim) begin
                  tbl_valid[i] = 1'b0;
                  freed++;
               end
         end
         v.freed = freed[FREED_W-1:0];
         return v;
      end
      for (i = 0; i < NUM_SLOTS && slot < 0; i++)
         if (tbl_valid[i] && tbl_key[i] == it.addr) slot = i;
      if (slot >= 0) begin
         // refill, saturating at burst; a backward step wraps and fills
         gap = 64'(it.now) - 64'(tbl_stamp[slot]);
         lvl = 64'(tbl_level[slot]);
         if (gap < burst * TICKS / rate) begin
            lvl = lvl + gap * rate / TICKS;
            if (lvl > burst) lvl = burst;
         end else begin
            lvl = burst;
         end
         tbl_stamp[slot] = it.now;
         if (lvl > 64'(it.size)) begin
            tbl_level[slot] = TOK_W'(lvl - 64'(it.size));
            v = '{1'b1, OUT_HIT_PASS, '0};
         end else begin
            tbl_level[slot] = TOK_W'(lvl);
            v = '{1'b0, OUT_HIT_DROP, '0};
         end
         return v;
      end
      if (64'(it.size) > burst) return '{1'b0, OUT_TOO_BIG, '0};
      for (i = 0; i < NUM_SLOTS && slot < 0; i++)
         if (!tbl_valid[i]) slot = i;
      if (slot < 0) return '{1'b0, OUT_FULL, '0};
      tbl_valid[slot] = 1'b1;
      tbl_key[slot]   = it.addr;
      tbl_level[slot] = TOK_W'(burst - 64'(it.size));
      tbl_stamp[slot] = it.now;
      return '{1'b1, OUT_NEW_PASS, '0};
   endfunction

   function automatic int sender_idle_pct();
      return (idle_mode == 0) ? 23 : (idle_mode == 1) ? 87 : 0;
   endfunction

   function automatic int receiver_idle_pct();
      return (idle_mode == 0) ? 87 : (idle_mode == 1) ? 23 : 0;
   endfunction

   // driver: predict on each transfer, then offer the next item
   always @(posedge clock) begin
      pkt_item_type it;
      if (req_valid && !req_stall)
         expected_verdicts.push_back(police_item('{req_mode, req_dest_addr,
                                                    req_pkt_size, req_now}));
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_pkts.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
            it = pending_pkts.pop_front();
            req_valid     <= 1'b1;
            req_mode      <= it.mode;
            req_dest_addr <= it.addr;
            req_pkt_size  <= it.size;
            req_now       <= it.now;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long hold-off so the block backs up into the request side
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 400;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: compare each result transfer, then choose the next stall
   always @(posedge clock) begin
      verdict_type exp_v;
      if (rsp_valid && !rsp_stall && !reset) begin
         if (expected_verdicts.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: fwd %0b outcome %0d freed %0d",
                                       rsp_forward, rsp_outcome, rsp_freed_count);
         end else begin
            exp_v = expected_verdicts.pop_front();
            if (rsp_forward !== exp_v.forward || rsp_outcome !== exp_v.outcome ||
                rsp_freed_count !== exp_v.freed) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp fwd %0b outcome %0d freed %0d, got %0b %0d %0d",
                           exp_v.forward, exp_v.outcome, exp_v.freed,
                           rsp_forward, rsp_outcome, rsp_freed_count);
            end
         end
      end
      if ((hold_req && !hold_done) || hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("tb_per_destination_token_bucket_policer: errors");
         $finish;
      end
   end

   task automatic push_item(logic mode, logic [KEY_W-1:0] addr, logic [SIZE_W-1:0] size,
                            logic [TIME_W-1:0] now);
      pending_pkts.push_back('{mode, addr, size, now});
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      if (idx == CSR_BURST) cfg_burst = val;
      else cfg_rate = val;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain();
      while (pending_pkts.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(negedge clock);
   endtask

   // random traffic: pool_sz of zero draws fully random addresses
   task automatic gen_traffic(int n, int pool_sz, int expire_pct, int step_max);
      logic [SIZE_W-1:0] size;
      logic [KEY_W-1:0]  addr;
      int                k;
      for (k = 0; k < n; k++) begin
         clk_now = clk_now + TIME_W'($urandom_range(step_max));
         addr = (pool_sz == 0) ? $urandom : addr_pool[$urandom_range(pool_sz - 1)];
         if ($urandom_range(9) == 0) size = SIZE_W'($urandom);
         else size = SIZE_W'($urandom_range(int'(cfg_burst) + int'(cfg_burst) / 8));
         push_item($urandom_range(99) >= expire_pct, addr, size, clk_now);
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < 64; i++) addr_pool[i] = $urandom;
      for (i = 0; i < NUM_SLOTS; i++) tbl_valid[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: every outcome but a full table, boundary sizes and keys, backward time
      write_csr(CSR_BURST, 16'd1000);
      write_csr(CSR_RATE, 16'd500);
      push_item(1'b0, 32'h0, 16'd0, 63'd5);
      push_item(1'b1, 32'h0, 16'd0, 63'd10);
      push_item(1'b1, 32'h0, 16'd0, 63'd10);
      push_item(1'b1, 32'h0, 16'hFFFF, 63'd20);
      push_item(1'b1, 32'hFFFF_FFFF, 16'd1001, 63'd20);
      push_item(1'b1, 32'hFFFF_FFFF, 16'd1000, 63'd30);
      push_item(1'b1, 32'hFFFF_FFFF, 16'd0, 63'd30);
      push_item(1'b1, 32'hFFFF_FFFF, 16'd5, 63'd30_000_030);
      push_item(1'b1, 32'hFFFF_FFFF, 16'd999, 63'd1_030_000_030);
      push_item(1'b1, 32'hFFFF_FFFF, 16'd1, 63'd1_000);
      push_item(1'b1, 32'h5A5A_A5A5, 16'd999, 63'd2_000);
      push_item(1'b0, 32'h0, 16'd0, 63'd1_999_999_999);
      push_item(1'b1, 32'h0, 16'd10, 63'd2_000_000_000);
      push_item(1'b0, 32'h0, 16'd0, 63'd2_000_001_500);
      push_item(1'b0, 32'h0, 16'd0, 63'd6_000_000_000);
      push_item(1'b1, 32'h1234_5678, 16'd1000, 63'd6_000_000_001);
      push_item(1'b1, 32'h1234_5678, 16'd1, 63'd6_000_000_002);
      clk_now = 63'd6_000_000_002;
      drain();

      // widest bucket, slowest rate, with a long receiver hold-off
      write_csr(CSR_BURST, 16'hFFFF);
      write_csr(CSR_RATE, 16'd1);
      hold_req = 1'b1;
      gen_traffic(200, 16, 8, 500_000_000);
      drain();

      // shallow bucket below existing levels, fastest rate, zero expiry age
      idle_mode = 1;
      write_csr(CSR_BURST, 16'd300);
      write_csr(CSR_RATE, 16'hFFFF);
      gen_traffic(200, 32, 10, 100_000);
      drain();

      // many distinct keys to fill the table; zero rate acts as one
      write_csr(CSR_BURST, 16'd5000);
      write_csr(CSR_RATE, 16'd0);
      gen_traffic(350, 0, 3, 1_000);
      drain();

      // empty bucket, then a mid setting that runs into the top of time
      idle_mode = 2;
      write_csr(CSR_BURST, 16'd0);
      write_csr(CSR_RATE, 16'hFFFF);
      gen_traffic(100, 8, 10, 1_000_000);
      drain();
      write_csr(CSR_BURST, 16'd40000);
      write_csr(CSR_RATE, 16'd3000);
      gen_traffic(100, 24, 10, 20_000_000);
      clk_now = 63'h7FFF_FFFF_0000_0000;
      gen_traffic(100, 24, 10, 20_000_000);
      drain();

      repeat (400) @(posedge clock);
      if (errors == 0 && expected_verdicts.size() == 0)
         $display("tb_per_destination_token_bucket_policer: clean");
      else
         $display("tb_per_destination_token_bucket_policer: errors");
      $finish;
   end

endmodule
